FILE: sv/osa_ed_pkg.sv
package osa_ed_pkg;

    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 7;
    localparam int DIST_SAT = 127;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    // control half of a token moving down the cell chain
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [CHAR_W-1:0] ch;        // appended or query char
        logic [CHAR_W-1:0] last_ch;   // previous query char
        logic [CHAR_W-1:0] left_ref;  // ref char held by the left neighbor
        logic              left_ok;   // left neighbor holds a ref char
        logic              first;     // first query row since start
        logic              err;       // sticky error, read at finish only
    } wave_ctl_t;

endpackage

FILE: sv/osa_ed_cell.sv
module osa_ed_cell #(
    parameter int W   = 7,
    parameter int COL = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  osa_ed_pkg::wave_ctl_t in_ctl,
    input  logic [W-1:0]          in_val,
    input  logic [W-1:0]          in_diag,
    input  logic [W-1:0]          in_pdiag,
    input  logic [W-1:0]          in_pdiag_l,
    input  logic [W-1:0]          in_idx,
    input  logic [W-1:0]          in_dist,
    output osa_ed_pkg::wave_ctl_t out_ctl,
    output logic [W-1:0]          out_val,
    output logic [W-1:0]          out_diag,
    output logic [W-1:0]          out_pdiag,
    output logic [W-1:0]          out_pdiag_l,
    output logic [W-1:0]          out_idx,
    output logic [W-1:0]          out_dist
);

    localparam logic [W-1:0] COL_V = W'(COL);
    localparam logic [W-1:0] POS_V = W'(COL - 1);

    logic [osa_ed_pkg::CHAR_W-1:0] ref_reg;
    logic [W-1:0]                  prev_reg;
    logic [W-1:0]                  pprev_reg;
    osa_ed_pkg::wave_ctl_t         ctl_reg;
    osa_ed_pkg::wave_ctl_t         ctl_next;
    logic [W-1:0]                  val_reg;
    logic [W-1:0]                  diag_reg;
    logic [W-1:0]                  pdiag_reg;
    logic [W-1:0]                  pdiag_l_reg;
    logic [W-1:0]                  idx_reg;
    logic [W-1:0]                  dist_reg;

    logic         cost;
    logic         tr_en;
    logic [W:0]   up_c;
    logic [W:0]   left_c;
    logic [W:0]   diag_c;
    logic [W:0]   tr_c;
    logic [W:0]   best;
    logic [W-1:0] new_val;

    always_comb
    begin
        cost   = (ref_reg != in_ctl.ch);
        tr_en  = !in_ctl.first && in_ctl.left_ok && (in_ctl.ch == in_ctl.left_ref) &&
                 (in_ctl.last_ch == ref_reg);
        up_c   = {1'b0, prev_reg} + (W+1)'(1);
        left_c = {1'b0, in_val} + (W+1)'(1);
        diag_c = {1'b0, in_diag} + (W+1)'(cost);
        tr_c   = {1'b0, in_pdiag_l} + (W+1)'(cost);
        best   = (up_c < left_c) ? up_c : left_c;
        if (diag_c < best)
        begin
            best = diag_c;
        end
        if (tr_en && (tr_c < best))
        begin
            best = tr_c;
        end
        new_val = best[W-1:0];

        ctl_next          = in_ctl;
        ctl_next.left_ref = ref_reg;
        ctl_next.left_ok  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg   <= '0;
            prev_reg  <= COL_V;
            pprev_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
            if (in_ctl.valid)
            begin
                case (in_ctl.op)
                    osa_ed_pkg::OP_START:
                    begin
                        prev_reg  <= COL_V;
                        pprev_reg <= '0;
                    end
                    osa_ed_pkg::OP_QUERY:
                    begin
                        prev_reg  <= new_val;
                        pprev_reg <= prev_reg;
                    end
                    default:
                    begin
                        prev_reg  <= prev_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_ctl.valid && (in_ctl.op == osa_ed_pkg::OP_APPEND) &&
            (in_idx == POS_V))
        begin
            ref_reg <= in_ctl.ch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_reg     <= new_val;
            diag_reg    <= prev_reg;
            pdiag_reg   <= pprev_reg;
            pdiag_l_reg <= in_pdiag;
            idx_reg     <= in_idx;
            if ((in_ctl.op == osa_ed_pkg::OP_FINISH) && (in_idx == COL_V))
            begin
                dist_reg <= prev_reg;
            end
            else
            begin
                dist_reg <= in_dist;
            end
        end
    end

    assign out_ctl     = ctl_reg;
    assign out_val     = val_reg;
    assign out_diag    = diag_reg;
    assign out_pdiag   = pdiag_reg;
    assign out_pdiag_l = pdiag_l_reg;
    assign out_idx     = idx_reg;
    assign out_dist    = dist_reg;

endmodule

FILE: sv/osa_edit_distance.sv
// A finish request passes the column-zero register, the MAX_LEN cell registers and
// the output register. One request per cycle while not stalled; every request walks
// the MAX_LEN-cell chain one cell per cycle, so query rows overlap as a wavefront.
// The whole chain stalls only while a result waits on the output register.
// Reset (rst_n low, asynchronous) equals a start request: empty strings, no error.
module osa_edit_distance #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic [1:0] s_axis_tuser,   // [1:0] op
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] distance, [7] zero
    output logic       m_axis_tuser    // [0] error_flag
);

    localparam int W = $clog2(MAX_LEN + 1);
    localparam logic [W-1:0] LEN_MAX = W'(MAX_LEN);

    osa_ed_pkg::wave_ctl_t w_ctl     [MAX_LEN+1];
    logic [W-1:0]          w_val     [MAX_LEN+1];
    logic [W-1:0]          w_diag    [MAX_LEN+1];
    logic [W-1:0]          w_pdiag   [MAX_LEN+1];
    logic [W-1:0]          w_pdiag_l [MAX_LEN+1];
    logic [W-1:0]          w_idx     [MAX_LEN+1];
    logic [W-1:0]          w_dist    [MAX_LEN+1];

    logic                          adv;
    logic                          s_acc;
    osa_ed_pkg::op_t               in_op;
    logic [osa_ed_pkg::CHAR_W-1:0] in_ch;

    logic [W-1:0]                  ref_len_reg, ref_len_next;
    logic [W-1:0]                  qc_reg, qc_next;
    logic [osa_ed_pkg::CHAR_W-1:0] last_ch_reg, last_ch_next;
    logic                          err_reg, err_next;

    osa_ed_pkg::wave_ctl_t w0_ctl_reg, w0_ctl_next;
    logic [W-1:0]          w0_val_reg, w0_diag_reg, w0_pdiag_reg, w0_idx_reg, w0_dist_reg;

    logic                          out_valid_reg;
    logic [osa_ed_pkg::DIST_W-1:0] out_dist_reg, out_dist_next;
    logic                          out_err_reg;
    logic [W+6:0]                  end_dist_ext;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign s_acc         = s_axis_tvalid && adv;
    assign in_op         = osa_ed_pkg::op_t'(s_axis_tuser);
    assign in_ch         = s_axis_tdata;

    always_comb
    begin
        ref_len_next = ref_len_reg;
        qc_next      = qc_reg;
        last_ch_next = last_ch_reg;
        err_next     = err_reg;
        w0_ctl_next  = '0;
        w0_ctl_next.op      = in_op;
        w0_ctl_next.ch      = in_ch;
        w0_ctl_next.last_ch = last_ch_reg;
        w0_ctl_next.first   = (qc_reg == '0);
        w0_ctl_next.err     = err_reg;
        if (s_acc)
        begin
            case (in_op)
                osa_ed_pkg::OP_START:
                begin
                    ref_len_next      = '0;
                    qc_next           = '0;
                    last_ch_next      = '0;
                    err_next          = 1'b0;
                    w0_ctl_next.valid = 1'b1;
                end
                osa_ed_pkg::OP_APPEND:
                begin
                    if ((qc_reg != '0) || (ref_len_reg >= LEN_MAX))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        ref_len_next      = ref_len_reg + W'(1);
                        w0_ctl_next.valid = 1'b1;
                    end
                end
                osa_ed_pkg::OP_QUERY:
                begin
                    if (qc_reg >= LEN_MAX)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        qc_next           = qc_reg + W'(1);
                        last_ch_next      = in_ch;
                        w0_ctl_next.valid = 1'b1;
                    end
                end
                default:
                begin
                    w0_ctl_next.valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg <= '0;
            qc_reg      <= '0;
            last_ch_reg <= '0;
            err_reg     <= 1'b0;
            w0_ctl_reg  <= '0;
        end
        else if (adv)
        begin
            ref_len_reg <= ref_len_next;
            qc_reg      <= qc_next;
            last_ch_reg <= last_ch_next;
            err_reg     <= err_next;
            w0_ctl_reg  <= w0_ctl_next;
        end
    end

    // column zero of the table: row i holds i
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w0_val_reg   <= qc_reg + W'(1);
            w0_diag_reg  <= qc_reg;
            w0_pdiag_reg <= (qc_reg == '0) ? '0 : qc_reg - W'(1);
            w0_idx_reg   <= ref_len_reg;
            w0_dist_reg  <= qc_reg;
        end
    end

    assign w_ctl[0]     = w0_ctl_reg;
    assign w_val[0]     = w0_val_reg;
    assign w_diag[0]    = w0_diag_reg;
    assign w_pdiag[0]   = w0_pdiag_reg;
    assign w_pdiag_l[0] = '0;
    assign w_idx[0]     = w0_idx_reg;
    assign w_dist[0]    = w0_dist_reg;

    for (genvar j = 1; j <= MAX_LEN; j++)
    begin : g_cell
        osa_ed_cell #(
            .W   (W),
            .COL (j)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .in_ctl      (w_ctl[j-1]),
            .in_val      (w_val[j-1]),
            .in_diag     (w_diag[j-1]),
            .in_pdiag    (w_pdiag[j-1]),
            .in_pdiag_l  (w_pdiag_l[j-1]),
            .in_idx      (w_idx[j-1]),
            .in_dist     (w_dist[j-1]),
            .out_ctl     (w_ctl[j]),
            .out_val     (w_val[j]),
            .out_diag    (w_diag[j]),
            .out_pdiag   (w_pdiag[j]),
            .out_pdiag_l (w_pdiag_l[j]),
            .out_idx     (w_idx[j]),
            .out_dist    (w_dist[j])
        );
    end

    always_comb
    begin
        end_dist_ext = (W+7)'(w_dist[MAX_LEN]);
        if (end_dist_ext > (W+7)'(osa_ed_pkg::DIST_SAT))
        begin
            out_dist_next = osa_ed_pkg::DIST_W'(osa_ed_pkg::DIST_SAT);
        end
        else
        begin
            out_dist_next = end_dist_ext[osa_ed_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= w_ctl[MAX_LEN].valid &&
                             (w_ctl[MAX_LEN].op == osa_ed_pkg::OP_FINISH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_dist_reg <= out_dist_next;
            out_err_reg  <= w_ctl[MAX_LEN].err;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_dist_reg};
    assign m_axis_tuser  = out_err_reg;

    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(w_ctl[MAX_LEN].valid && (w_ctl[MAX_LEN].op == osa_ed_pkg::OP_FINISH)))
        else $error("result without finish token at chain end");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (qc_reg <= LEN_MAX) && (ref_len_reg <= LEN_MAX))
        else $error("length counter past MAX_LEN");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg && !(s_acc && (in_op == osa_ed_pkg::OP_START))) |=> err_reg)
        else $error("error flag dropped without start");

    a_late_append: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && (in_op == osa_ed_pkg::OP_APPEND) && (qc_reg != '0)) |=>
            !(w_ctl[0].valid && (w_ctl[0].op == osa_ed_pkg::OP_APPEND)))
        else $error("late append entered the chain");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(w_ctl[MAX_LEN]))
        else $error("chain moved during output stall");

endmodule
